@@ rtl/core/icymd_pkg.sv @@
// Shared types and constants for the ICY metadata stream demultiplexer.
package icymd_pkg;

   // Width of the audio byte counter; the interval saturates at its maximum
   localparam int COUNT_W      = 16;
   localparam int INTERVAL_W   = 16;
   localparam int CMP_W        = (COUNT_W > INTERVAL_W) ? COUNT_W : INTERVAL_W;
   localparam int META_REM_W   = 12;
   localparam int META_UNIT    = 16;
   localparam int META_SHIFT   = $clog2(META_UNIT);
   localparam int EOH_LEN      = 5;
   localparam int EOH_W        = 3;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [EOH_W-1:0] EOH_LAST = EOH_W'(EOH_LEN - 1);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd8192;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_META_INTERVAL = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SKIP_HEADER   = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_AUDIO  = 2'd1,
      PH_META   = 2'd2,
      PH_HALT   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CLS_HEADER = 2'd0,
      CLS_AUDIO  = 2'd1,
      CLS_LENGTH = 2'd2,
      CLS_META   = 2'd3
   } class_type;

   typedef struct packed {
      phase_type               phase;
      logic [EOH_W-1:0]        eoh_match;
      logic [COUNT_W-1:0]      audio_count;
      logic [META_REM_W-1:0]   meta_remaining;
   } parse_state_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0]   meta_interval;
      logic                    skip_header;
   } cfg_type;

   typedef struct packed {
      class_type               byte_class;
      logic                    meta_last;
      logic                    header_done;
      logic                    fault;
   } result_type;

endpackage

@@ rtl/core/icy_metadata_stream_demux.sv @@
// Top level of the ICY metadata stream demultiplexer.
//
// Usage: received stream bytes enter on the req_ channel one per transfer,
// with req_tuser carrying the new-connection flag that restarts the parser
// before that byte. Each byte leaves on the rsp_ channel unchanged in
// rsp_tdata, tagged in rsp_tuser with its class (header/dropped, audio,
// metadata length, metadata) plus header-done and fault flags; rsp_tlast
// marks the byte that completes a metadata block (or a zero length byte).
// The csr_ port writes meta_interval (index 0) and skip_header (index 1);
// write only while no bytes are in flight.
// An accepted transfer reaches the result register in the next cycle.
// Throughput is one byte per cycle while the receiver takes each result:
// the parser state and result register both load at every accepted transfer.
// Reset clears the parser to the header phase, empties the result register
// and restores meta_interval to 8192 and skip_header to 1.
// When the receiver stalls, the result register holds, and req_tready
// drops until that result is taken; a result taken in the same cycle
// frees the register for the next byte.
module icy_metadata_stream_demux (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: data_byte[7:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,
   // req_tuser: new_connection[0]
   input  logic                                 req_tuser,
   // rsp_tdata: out_byte[7:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,
   // rsp_tuser: byte_class[1:0], header_done[2], fault[3]
   output logic [3:0]                           rsp_tuser,
   // rsp_tlast: meta_last
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [icymd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [icymd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import icymd_pkg::*;

   cfg_type         cfg_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_in;
   result_type      result_ff;
   logic [7:0]      byte_ff;
   logic            valid_ff;
   logic            accept;

   assign req_tready = !reset && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   icymd_step u_step (
      .state_cur      (state_ff),
      .cfg            (cfg_ff),
      .new_connection (req_tuser),
      .data_byte      (req_tdata),
      .state_nxt      (state_in),
      .result         (result_in)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.meta_interval <= INTERVAL_RESET;
         cfg_ff.skip_header   <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_META_INTERVAL: cfg_ff.meta_interval <= csr_wdata[INTERVAL_W-1:0];
            CSR_SKIP_HEADER:   cfg_ff.skip_header   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Parser state advances on every accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_HEADER, eoh_match: '0, audio_count: '0, meta_remaining: '0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
         byte_ff   <= req_tdata;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {result_ff.fault, result_ff.header_done, result_ff.byte_class};
   assign rsp_tlast  = result_ff.meta_last;

endmodule

@@ rtl/core/icymd_step.sv @@
// Next-state and result logic for one stream byte.
module icymd_step (
   input  icymd_pkg::parse_state_type state_cur,
   input  icymd_pkg::cfg_type         cfg,
   input  logic                       new_connection,
   input  logic [7:0]                 data_byte,
   output icymd_pkg::parse_state_type state_nxt,
   output icymd_pkg::result_type      result
);
   import icymd_pkg::*;

   parse_state_type st;
   parse_state_type s_in;
   parse_state_type s_out;
   result_type      s_res;
   logic [EOH_W-1:0] eoh_nxt;
   logic            eoh_done;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] interval_ext;
   logic [CMP_W-1:0] count_max;
   logic [CMP_W-1:0] limit;
   logic [META_REM_W-1:0] rem_dec;
   logic [META_REM_W-1:0] rem_load;
   logic            interval_zero;
   logic            is_cr;
   logic            is_lf;

   // New connection clears the parser before the byte is handled
   always_comb begin
      if (new_connection) begin
         st = '{phase: PH_HEADER, eoh_match: '0, audio_count: '0, meta_remaining: '0};
      end else begin
         st = state_cur;
      end
   end

   assign is_cr         = (data_byte == CHAR_CR);
   assign is_lf         = (data_byte == CHAR_LF);
   assign interval_zero = (cfg.meta_interval == '0);

   // End-of-header matcher: non-CR/LF byte then CR LF CR LF
   always_comb begin
      eoh_done = 1'b0;
      if (!is_cr && !is_lf) begin
         eoh_nxt = EOH_W'(1);
      end else if (is_cr && (st.eoh_match == EOH_W'(1) || st.eoh_match == EOH_W'(3))) begin
         eoh_nxt = st.eoh_match + EOH_W'(1);
      end else if (is_lf && st.eoh_match == EOH_W'(2)) begin
         eoh_nxt = EOH_W'(3);
      end else if (is_lf && st.eoh_match == EOH_LAST) begin
         eoh_nxt  = '0;
         eoh_done = 1'b1;
      end else begin
         eoh_nxt = '0;
      end
   end

   // Stream input: header with skipping off enters audio with cleared counts
   always_comb begin
      s_in = st;
      if (st.phase == PH_HEADER) begin
         s_in.phase          = PH_AUDIO;
         s_in.audio_count    = '0;
         s_in.meta_remaining = '0;
      end
   end

   // Interval limit, saturated to what the counter can hold
   assign count_ext    = CMP_W'(s_in.audio_count);
   assign interval_ext = CMP_W'(cfg.meta_interval);
   assign count_max    = CMP_W'({COUNT_W{1'b1}});
   assign limit        = (interval_ext > count_max) ? count_max : interval_ext;
   assign rem_dec      = s_in.meta_remaining - META_REM_W'(1);
   assign rem_load     = META_REM_W'(data_byte) << META_SHIFT;

   // Audio / length / metadata cycle
   always_comb begin
      s_out = s_in;
      s_res = '{byte_class: CLS_HEADER, meta_last: 1'b0, header_done: 1'b0, fault: 1'b0};
      if (s_in.phase == PH_META) begin
         s_res.byte_class     = CLS_META;
         s_out.meta_remaining = rem_dec;
         if (rem_dec == '0) begin
            s_res.meta_last = 1'b1;
            s_out.phase     = PH_AUDIO;
         end
      end else if (count_ext < limit) begin
         s_res.byte_class  = CLS_AUDIO;
         s_out.audio_count = s_in.audio_count + COUNT_W'(1);
      end else begin
         s_res.byte_class     = CLS_LENGTH;
         s_out.audio_count    = '0;
         s_out.meta_remaining = rem_load;
         if (rem_load == '0) begin
            s_res.meta_last = 1'b1;
            s_out.phase     = PH_AUDIO;
         end else begin
            s_out.phase = PH_META;
         end
      end
   end

   // Top-level phase selection
   always_comb begin
      state_nxt = st;
      result    = '{byte_class: CLS_HEADER, meta_last: 1'b0, header_done: 1'b0, fault: 1'b0};
      case (st.phase)
         PH_HEADER: begin
            if (cfg.skip_header) begin
               state_nxt.eoh_match = eoh_nxt;
               if (eoh_done) begin
                  result.header_done = 1'b1;
                  if (interval_zero) begin
                     result.fault    = 1'b1;
                     state_nxt.phase = PH_HALT;
                  end else begin
                     state_nxt.phase          = PH_AUDIO;
                     state_nxt.audio_count    = '0;
                     state_nxt.meta_remaining = '0;
                  end
               end
            end else if (interval_zero) begin
               result.fault    = 1'b1;
               state_nxt.phase = PH_HALT;
            end else begin
               state_nxt = s_out;
               result    = s_res;
            end
         end
         PH_AUDIO, PH_META: begin
            state_nxt = s_out;
            result    = s_res;
         end
         default: begin
            // halted: drop everything until a new connection
         end
      endcase
   end

endmodule

@@ rtl/core/icymd_checker.sv @@
// Port-level assertions for the ICY metadata stream demultiplexer, with bind.
module icymd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [7:0]                       req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [7:0]                       rsp_tdata,
   input logic [3:0]                       rsp_tuser,
   input logic                             rsp_tlast
);
   import icymd_pkg::*;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its byte
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // An accepted transfer shows its result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid && rsp_tdata == $past(req_tdata))
      else $error("result missing one cycle after transfer");

   // A fault byte is dropped and ends no metadata block
   a_fault_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[1:0] == CLS_HEADER && !rsp_tlast)
      else $error("fault byte not dropped");

   // Block end only on a length or metadata byte
   a_last_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tuser[1:0] == CLS_LENGTH || rsp_tuser[1:0] == CLS_META)
      else $error("meta_last on wrong byte class");

endmodule

bind icy_metadata_stream_demux icymd_checker u_icymd_checker (.*);

@@ dv/icy_metadata_stream_demux_tb.sv @@
// Self-checking testbench for the ICY metadata stream demultiplexer.
module icy_metadata_stream_demux_tb;
   import icymd_pkg::*;

   localparam int PHASES     = 12;
   localparam int IDLE_LIMIT = 2000;
   localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_W) - 64'd1);

   // Expected tag of one byte
   typedef struct {
      class_type   byte_class;
      logic [7:0]  out_byte;
      logic        meta_last;
      logic        header_done;
      logic        fault;
   } byte_tag_type;

   // Parser predictor plus the queue of tags it has produced
   class byte_tag_scoreboard;
      logic [INTERVAL_W-1:0] meta_interval;
      logic                  skip_header;
      phase_type             phase;
      logic [EOH_W-1:0]      eoh_match;
      logic [COUNT_W-1:0]    audio_count;
      logic [META_REM_W-1:0] meta_left;
      byte_tag_type          expected_tags[$];
      int                    errors;

      function new();
         meta_interval = INTERVAL_RESET;
         skip_header   = 1'b1;
         errors        = 0;
         restart_parser();
      endfunction

      function void restart_parser();
         phase       = PH_HEADER;
         eoh_match   = '0;
         audio_count = '0;
         meta_left   = '0;
      endfunction

      function void enter_stream();
         phase       = PH_AUDIO;
         audio_count = '0;
         meta_left   = '0;
      endfunction

      // Blank-line matcher; 1 when the pattern completes
      function bit match_header(logic [7:0] b);
         if (b != CHAR_CR && b != CHAR_LF) begin
            eoh_match = EOH_W'(1);
            return 1'b0;
         end
         if (b == CHAR_CR && (eoh_match == EOH_W'(1) || eoh_match == EOH_W'(3))) begin
            eoh_match = eoh_match + 1'b1;
            return 1'b0;
         end
         if (b == CHAR_LF && eoh_match == EOH_W'(2)) begin
            eoh_match = EOH_W'(3);
            return 1'b0;
         end
         if (b == CHAR_LF && eoh_match == EOH_LAST) begin
            eoh_match = '0;
            return 1'b1;
         end
         eoh_match = '0;
         return 1'b0;
      endfunction

      // Audio / length / metadata cycle
      function void tag_stream_byte(logic [7:0] b, inout byte_tag_type tag);
         logic [CMP_W-1:0] lim;
         if (phase == PH_META) begin
            tag.byte_class = CLS_META;
            meta_left = meta_left - 1'b1;
            if (meta_left == '0) begin
               tag.meta_last = 1'b1;
               phase = PH_AUDIO;
            end
            return;
         end
         lim = CMP_W'(meta_interval);
         if (lim > COUNT_MAX)
            lim = COUNT_MAX;
         if (CMP_W'(audio_count) < lim) begin
            tag.byte_class = CLS_AUDIO;
            audio_count = audio_count + 1'b1;
            return;
         end
         tag.byte_class = CLS_LENGTH;
         audio_count = '0;
         meta_left = META_REM_W'(b) << META_SHIFT;
         if (meta_left == '0) begin
            tag.meta_last = 1'b1;
            phase = PH_AUDIO;
         end else begin
            phase = PH_META;
         end
      endfunction

      // Accepted input transfer: advance the parser and queue the tag
      function void note_byte(bit new_conn, logic [7:0] b);
         byte_tag_type tag;
         tag.byte_class  = CLS_HEADER;
         tag.out_byte    = b;
         tag.meta_last   = 1'b0;
         tag.header_done = 1'b0;
         tag.fault       = 1'b0;
         if (new_conn)
            restart_parser();
         case (phase)
            PH_HEADER: begin
               if (skip_header) begin
                  if (match_header(b)) begin
                     tag.header_done = 1'b1;
                     if (meta_interval == '0) begin
                        tag.fault = 1'b1;
                        phase = PH_HALT;
                     end else begin
                        enter_stream();
                     end
                  end
               end else if (meta_interval == '0) begin
                  tag.fault = 1'b1;
                  phase = PH_HALT;
               end else begin
                  enter_stream();
                  tag_stream_byte(b, tag);
               end
            end
            PH_AUDIO, PH_META: tag_stream_byte(b, tag);
            default: ;
         endcase
         expected_tags.push_back(tag);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         errors++;
      endtask

      // Result transfer: compare against the oldest tag
      task check_byte(logic [7:0] data, logic [3:0] user, logic tlast);
         byte_tag_type want;
         if (expected_tags.size() == 0) begin
            report_mismatch($sformatf("result byte %02h with nothing pending", data));
            return;
         end
         want = expected_tags.pop_front();
         if (user[1:0] != want.byte_class)
            report_mismatch($sformatf("byte %02h class %0d, want %0d",
                                      data, user[1:0], want.byte_class));
         if (data != want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", data, want.out_byte));
         if (tlast != want.meta_last)
            report_mismatch($sformatf("byte %02h meta_last %0b, want %0b",
                                      data, tlast, want.meta_last));
         if (user[2] != want.header_done)
            report_mismatch($sformatf("byte %02h header_done %0b, want %0b",
                                      data, user[2], want.header_done));
         if (user[3] != want.fault)
            report_mismatch($sformatf("byte %02h fault %0b, want %0b",
                                      data, user[3], want.fault));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic [3:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   byte_tag_scoreboard sb;
   logic [7:0]         header_script[$];
   logic [8:0]         probe_bytes[$];   // {new_connection, data_byte}
   bit                 req_steady = 1'b0;
   bit                 rsp_steady = 1'b0;
   int                 rsp_wait = 0;
   int                 idle_cycles = 0;

   icy_metadata_stream_demux dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // One input transfer, after a random gap unless req_steady is set
   task automatic send_byte(bit new_conn, logic [7:0] b);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= new_conn;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(new_conn, b);
   endtask

   task automatic send_probe();
      foreach (probe_bytes[i])
         send_byte(probe_bytes[i][8], probe_bytes[i][7:0]);
   endtask

   // Drain, then write both registers
   task automatic apply_settings(logic [INTERVAL_W-1:0] interval, bit skip);
      req_tvalid <= 1'b0;
      while (sb.expected_tags.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_META_INTERVAL;
      csr_wdata <= CSR_DATA_W'(interval);
      sb.meta_interval = interval;
      @(posedge clock);
      csr_addr  <= CSR_SKIP_HEADER;
      csr_wdata <= CSR_DATA_W'(skip);
      sb.skip_header = skip;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Next stream byte, shaped by where the parser stands
   function automatic logic [7:0] choose_byte(bit new_conn);
      logic [7:0] b;
      logic [7:0] v;
      int r;
      int n;
      int lines;
      b = 8'($urandom);
      if (new_conn || sb.phase == PH_HEADER) begin
         if (new_conn)
            header_script.delete();
         if (sb.skip_header) begin
            if (header_script.size() == 0) begin
               // one to three text lines, then the blank line
               lines = $urandom_range(1, 3);
               for (int l = 0; l < lines; l++) begin
                  // stray CR/LF now and then to break the match
                  if ($urandom_range(0, 3) == 0) begin
                     n = $urandom_range(1, 3);
                     for (int k = 0; k < n; k++)
                        header_script.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                  end
                  n = $urandom_range(1, 6);
                  for (int k = 0; k < n; k++) begin
                     v = 8'($urandom);
                     if (v == CHAR_CR || v == CHAR_LF)
                        v = v ^ 8'h40;
                     header_script.push_back(v);
                  end
                  header_script.push_back(CHAR_CR);
                  header_script.push_back(CHAR_LF);
               end
               header_script.push_back(CHAR_CR);
               header_script.push_back(CHAR_LF);
            end
            b = header_script.pop_front();
         end
      end else if (sb.phase == PH_AUDIO && sb.audio_count >= sb.meta_interval) begin
         // length byte due: mostly short blocks, rarely long ones
         r = $urandom_range(0, 99);
         if (r < 35)
            b = 8'd0;
         else if (r < 85)
            b = 8'd1;
         else if (r < 98)
            b = 8'($urandom_range(2, 8));
         else
            b = 8'($urandom_range(9, 255));
      end
      // line noise
      r = $urandom_range(0, 49);
      if (r == 0)
         b = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
      else if (r == 1)
         b = 8'($urandom);
      return b;
   endfunction

   // Result side: random stalls, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         sb.check_byte(rsp_tdata, rsp_tuser, rsp_tlast);
         if ($urandom_range(0, 63) == 0)
            rsp_steady = !rsp_steady;
         rsp_wait = rsp_steady ? 0 : $urandom_range(0, 19);
         rsp_tready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= (rsp_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [INTERVAL_W-1:0] iv;
      bit                    sk;
      bit                    fresh;
      bit                    nc;
      logic [7:0]            b;
      int                    count;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Header matcher at reset settings: broken patterns, then a clean end
      probe_bytes = '{{1'b1, 8'h48}, {1'b0, CHAR_CR}, {1'b0, CHAR_LF}, {1'b0, CHAR_CR},
                      {1'b0, 8'h78}, {1'b0, CHAR_CR}, {1'b0, CHAR_CR}, {1'b0, CHAR_LF},
                      {1'b0, 8'h79}, {1'b0, CHAR_CR}, {1'b0, CHAR_LF}, {1'b0, CHAR_CR},
                      {1'b0, CHAR_LF}, {1'b0, 8'h00}, {1'b0, 8'hFF}};
      send_probe();

      // Interval 1 mid-stream: zero length, then an eight-unit block
      apply_settings(16'd1, 1'b0);
      probe_bytes = '{{1'b0, 8'h00}, {1'b0, 8'hA5}, {1'b0, 8'h08}};
      send_probe();
      for (int k = 0; k < 8 * META_UNIT; k++)
         send_byte(1'b0, 8'($urandom));
      // new connection with header skipping off, then a one-unit block
      probe_bytes = '{{1'b1, 8'h5A}, {1'b0, 8'h01}};
      send_probe();
      for (int k = 0; k < META_UNIT; k++)
         send_byte(1'b0, 8'($urandom));

      // Zero interval at header end: fault, then halted bytes
      apply_settings(16'd0, 1'b1);
      probe_bytes = '{{1'b1, 8'h41}, {1'b0, CHAR_CR}, {1'b0, CHAR_LF}, {1'b0, CHAR_CR},
                      {1'b0, CHAR_LF}, {1'b0, 8'h7E}, {1'b0, CHAR_CR}};
      send_probe();
      // zero interval with skipping off faults on the first byte
      apply_settings(16'd0, 1'b0);
      probe_bytes = '{{1'b1, 8'h10}, {1'b0, 8'h20}};
      send_probe();

      // Random phases, extremes first
      for (int p = 0; p < PHASES; p++) begin
         fresh = $urandom_range(0, 1);
         case (p)
            0: begin iv = 16'd1;     sk = 1'b1; fresh = 1'b1; end
            1: begin iv = 16'hFFFF;  sk = 1'b0; fresh = 1'b1; end
            2: begin iv = 16'd0;     sk = 1'b0; fresh = 1'b0; end
            3: begin iv = 16'd0;     sk = 1'b1; fresh = 1'b1; end
            default: begin
               sk = $urandom_range(0, 1);
               case ($urandom_range(0, 9))
                  0:       iv = 16'd0;
                  1:       iv = 16'hFFFF;
                  2:       iv = 16'd1;
                  9:       iv = 16'($urandom_range(13, 300));
                  default: iv = 16'($urandom_range(2, 12));
               endcase
            end
         endcase
         apply_settings(iv, sk);
         req_steady = ($urandom_range(0, 3) == 0);
         count = $urandom_range(30, 80);
         for (int i = 0; i < count; i++) begin
            if (sb.phase == PH_HALT)
               nc = ($urandom_range(0, 3) == 0);
            else
               nc = ($urandom_range(0, 299) == 0);
            if (i == 0 && fresh)
               nc = 1'b1;
            b = choose_byte(nc);
            send_byte(nc, b);
         end
      end

      // Drain and settle
      req_tvalid <= 1'b0;
      while (sb.expected_tags.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ icy_metadata_stream_demux.f @@
rtl/core/icymd_pkg.sv
rtl/core/icymd_step.sv
rtl/core/icy_metadata_stream_demux.sv
rtl/core/icymd_checker.sv
dv/icy_metadata_stream_demux_tb.sv
